// ===== rtl/core/variable_record_ring_queue_defines.svh =====
// assertion macros for the variable record ring queue
`ifndef VARIABLE_RECORD_RING_QUEUE_DEFINES_SVH
`define VARIABLE_RECORD_RING_QUEUE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define VRQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VRQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vrq_pkg.sv =====
// shared types, constants and codes of the variable record ring queue
package vrq_pkg;

    localparam int CAPACITY     = 1024;
    localparam int HEADER_BYTES = 4;
    localparam int MAX_RECORD   = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam int POS_W  = $clog2(CAPACITY);
    localparam int FREE_W = $clog2(CAPACITY + 1);
    localparam int HCNT_W = $clog2(HEADER_BYTES + 1);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // input kind codes
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_PEEK  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       first_byte;
        logic [6:0] length;
        logic [7:0] data_in;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_out;
        logic        last;
        logic [10:0] free_space;
        logic        is_empty;
    } t_result;

    // operation classes handed from front to back
    typedef enum logic [2:0] {
        OP_PUSH_FIRST,
        OP_PUSH_CONT,
        OP_POP,
        OP_PEEK,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] length;
        logic [7:0] data;
    } t_job;

    // back end status seen by the top level
    typedef struct packed {
        logic [FREE_W-1:0] free_bytes;
        logic              idle;
    } t_back_stat;

endpackage

// ===== rtl/core/vrq_front.sv =====
// front end: accepts commands and classifies them into jobs
module vrq_front
    import vrq_pkg::*;
(
    input  logic  start,
    output logic  busy,
    input  t_item i_item,
    input  logic  i_q_full,
    output logic  o_q_push,
    output t_job  o_q_job
);

    // transfer happens when the job queue has room
    assign busy     = i_q_full;
    assign o_q_push = start && !i_q_full;

    // classify the command
    always_comb begin
        o_q_job.length = i_item.length;
        o_q_job.data   = i_item.data_in;
        case (i_item.kind)
            KIND_PUSH:  o_q_job.op = i_item.first_byte ? OP_PUSH_FIRST : OP_PUSH_CONT;
            KIND_POP:   o_q_job.op = OP_POP;
            KIND_PEEK:  o_q_job.op = OP_PEEK;
            KIND_CLEAR: o_q_job.op = OP_CLEAR;
            default:    o_q_job.op = OP_CLEAR;
        endcase
    end

endmodule

// ===== rtl/core/vrq_queue.sv =====
// short job queue between front and back
module vrq_queue
    import vrq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/vrq_back.sv =====
// back end: ring store, record bookkeeping and result generation
module vrq_back
    import vrq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_q_head,
    output logic       o_q_pop,
    output logic       o_strobe,
    output t_result    o_result,
    output t_back_stat o_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_HDR,
        S_DATA
    } t_state;

    // ring store
    logic [7:0] r_ring [CAPACITY];
    logic [7:0] r_rdata;

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [POS_W-1:0]  r_rp, n_rp;
    logic [POS_W-1:0]  r_wp, n_wp;
    logic [FREE_W-1:0] r_free, n_free;
    logic [6:0]        r_pbl, n_pbl;
    logic              r_drop, n_drop;
    logic [HCNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_hdr0, n_hdr0;
    logic              r_hdr_hi, n_hdr_hi;
    logic [6:0]        r_issue, n_issue;
    logic [6:0]        r_emit, n_emit;
    logic              r_pend, n_pend;
    logic              r_valid, n_valid;
    t_result           r_res, n_res;

    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic [FREE_W-1:0] need;
    logic              reject;
    logic [7:0]        cur_b0;
    logic              cur_hi;
    logic [6:0]        rec;
    logic [6:0]        deliver;
    logic [POS_W:0]    rp_sum;
    logic [FREE_W:0]   free_sum;
    logic              emit;
    logic [1:0]        emit_status;
    logic [7:0]        emit_data;
    logic              emit_last;

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        next_pos = (p == POS_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_strobe = r_valid;
    assign o_result = r_res;
    assign o_stat   = '{free_bytes: r_free, idle: (r_state == S_IDLE)};

    // space check for a new record
    assign need   = FREE_W'(i_q_head.length) + FREE_W'(HEADER_BYTES);
    assign reject = (i_q_head.length > 7'(MAX_RECORD)) || (r_free < need);

    // header evaluation with the byte arriving this cycle
    assign cur_b0  = (r_cnt == HCNT_W'(1)) ? r_rdata : r_hdr0;
    assign cur_hi  = r_hdr_hi || ((r_cnt > HCNT_W'(1)) && (r_rdata != 8'd0));
    assign rec     = (cur_hi || (cur_b0 > 8'(MAX_RECORD))) ? 7'(MAX_RECORD) : cur_b0[6:0];
    assign deliver = (rec < r_job.length) ? rec : r_job.length;
    assign rp_sum  = (POS_W+1)'(r_rp) + (POS_W+1)'(rec) + (POS_W+1)'(HEADER_BYTES);
    assign free_sum = (FREE_W+1)'(r_free) + (FREE_W+1)'(rec) + (FREE_W+1)'(HEADER_BYTES);

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_free      = r_free;
        n_pbl       = r_pbl;
        n_drop      = r_drop;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_hdr0      = r_hdr0;
        n_hdr_hi    = r_hdr_hi;
        n_issue     = r_issue;
        n_emit      = r_emit;
        n_pend      = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = r_job.data;
        emit        = 1'b0;
        emit_status = ST_DONE;
        emit_data   = 8'd0;
        emit_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_job = i_q_head;
                    case (i_q_head.op)
                        OP_PUSH_FIRST: begin
                            if (reject) begin
                                n_drop      = 1'b1;
                                n_pbl       = 7'd0;
                                emit        = 1'b1;
                                emit_status = ST_NOSPACE;
                            end else begin
                                n_drop  = 1'b0;
                                n_free  = r_free - need;
                                n_cnt   = '0;
                                n_state = S_WRITE;
                            end
                        end
                        OP_PUSH_CONT: begin
                            emit = 1'b1;
                            if (r_drop) begin
                                emit_status = ST_NOSPACE;
                            end else if (r_pbl != 7'd0) begin
                                mem_we      = 1'b1;
                                mem_wdata   = i_q_head.data;
                                n_wp        = next_pos(r_wp);
                                n_pbl       = r_pbl - 1'b1;
                                emit_status = ST_OK;
                            end else begin
                                emit_status = ST_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            n_wp        = r_rp;
                            n_free      = FREE_W'(CAPACITY);
                            n_pbl       = 7'd0;
                            n_drop      = 1'b0;
                            emit        = 1'b1;
                            emit_status = ST_DONE;
                        end
                        default: begin
                            // pop or peek
                            if (r_free == FREE_W'(CAPACITY)) begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                            end else begin
                                n_pos    = r_rp;
                                n_cnt    = '0;
                                n_hdr_hi = 1'b0;
                                n_state  = S_HDR;
                            end
                        end
                    endcase
                end
            end
            S_WRITE: begin
                // header bytes little endian, then the first data byte unless the length is zero
                mem_we = 1'b1;
                n_wp   = next_pos(r_wp);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    mem_wdata = {1'b0, r_job.length};
                end else if (r_cnt < HCNT_W'(HEADER_BYTES)) begin
                    mem_wdata = 8'd0;
                end else begin
                    mem_wdata = r_job.data;
                end
                if (((r_cnt == HCNT_W'(HEADER_BYTES - 1)) && (r_job.length == 7'd0))
                        || (r_cnt == HCNT_W'(HEADER_BYTES))) begin
                    n_pbl       = (r_job.length == 7'd0) ? 7'd0 : r_job.length - 1'b1;
                    emit        = 1'b1;
                    emit_status = ST_OK;
                    n_state     = S_IDLE;
                end
            end
            S_HDR: begin
                // issue header reads, collect each in the cycle after it is issued
                if (r_cnt < HCNT_W'(HEADER_BYTES)) begin
                    n_pos = next_pos(r_pos);
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == HCNT_W'(1)) begin
                    n_hdr0 = r_rdata;
                end else if ((r_cnt > HCNT_W'(1)) && (r_rdata != 8'd0)) begin
                    n_hdr_hi = 1'b1;
                end
                if (r_cnt == HCNT_W'(HEADER_BYTES)) begin
                    if (r_job.op == OP_POP) begin
                        n_rp   = (rp_sum >= (POS_W+1)'(CAPACITY))
                                 ? POS_W'(rp_sum - (POS_W+1)'(CAPACITY)) : POS_W'(rp_sum);
                        n_free = (free_sum > (FREE_W+1)'(CAPACITY))
                                 ? FREE_W'(CAPACITY) : FREE_W'(free_sum);
                    end
                    if (deliver == 7'd0) begin
                        emit        = 1'b1;
                        emit_status = ST_DONE;
                        n_state     = S_IDLE;
                    end else begin
                        n_issue = deliver;
                        n_emit  = deliver;
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                // one read issued and one byte delivered per cycle
                if (r_issue != 7'd0) begin
                    n_pos   = next_pos(r_pos);
                    n_issue = r_issue - 1'b1;
                    n_pend  = 1'b1;
                end
                if (r_pend) begin
                    emit        = 1'b1;
                    emit_status = ST_OK;
                    emit_data   = r_rdata;
                    emit_last   = (r_emit == 7'd1);
                    n_emit      = r_emit - 1'b1;
                    if (r_emit == 7'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_valid = emit;
        n_res   = '{status:     emit_status,
                    data_out:   emit_data,
                    last:       emit_last,
                    free_space: 11'(n_free),
                    is_empty:   (n_free == FREE_W'(CAPACITY))};
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_free  <= FREE_W'(CAPACITY);
            r_pbl   <= 7'd0;
            r_drop  <= 1'b0;
            r_issue <= 7'd0;
            r_emit  <= 7'd0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_free  <= n_free;
            r_pbl   <= n_pbl;
            r_drop  <= n_drop;
            r_issue <= n_issue;
            r_emit  <= n_emit;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_job    <= n_job;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_hdr0   <= n_hdr0;
        r_hdr_hi <= n_hdr_hi;
        r_res    <= n_res;
    end

    // ring store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wp] <= mem_wdata;
        end
        r_rdata <= r_ring[r_pos];
    end

endmodule

// ===== rtl/core/variable_record_ring_queue.sv =====
// top level of the variable record ring queue
// A ring of CAPACITY bytes holds length-prefixed records (HEADER_BYTES-byte
// little-endian header, then the data). A command transfers when start is
// high and busy is low; commands wait in a two-entry job queue, and busy is
// high only while that queue is full. Results come out one per cycle with
// o_strobe and cannot be held off, so the receiver must take every one.
// The ring store has a single write and a single read port, and the back
// end takes the next job only while idle. Push continuation, clear, and
// pop or peek of an empty queue finish in the idle state; a first push
// byte writes the header and then the data byte one byte a cycle (no data
// byte for a record of zero length); pop and peek read the header one
// byte a cycle, then read and deliver the data one byte per cycle.
// Results are registered and appear in the cycle after the back end
// produces them.
`include "variable_record_ring_queue_defines.svh"

module variable_record_ring_queue
    import vrq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    logic       q_full;
    logic       q_push;
    t_job       q_job;
    logic       q_pop;
    logic       q_valid;
    t_job       q_head;
    t_back_stat back_stat;
    logic       chk_empty;
    logic       chk_nodata;
    logic       chk_single;

    // command intake and classification
    vrq_front u_front (
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_job)
    );

    // job queue
    vrq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // execution and ring store
    vrq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .o_stat    (back_stat)
    );

    // result classes seen by the checks
    assign chk_empty  = o_strobe && (o_result.status == ST_EMPTY);
    assign chk_nodata = o_strobe && (o_result.status != ST_OK);
    assign chk_single = o_result.last && (o_result.data_out == 8'd0);

    // checks
    `VRQ_ASSERT_ALWAYS(a_free_bounded, back_stat.free_bytes <= FREE_W'(CAPACITY), "free above capacity")
    `VRQ_ASSERT_IMPLY(a_empty_flag, chk_empty, o_result.is_empty, "empty status without empty flag")
    `VRQ_ASSERT_IMPLY(a_nodata_single, chk_nodata, chk_single, "non-data result not single")
    `VRQ_ASSERT_IMPLY(a_queue_order, q_pop, q_valid && back_stat.idle, "job taken out of order")

endmodule
